>>> src/drp_pkg.sv
`timescale 1ns / 1ps

package drp_pkg;

    localparam int VOLT_W         = 13;
    localparam int CURR_W         = 11;
    localparam int CODE_W         = 16;
    localparam int RAMP_STEPS_DEF = 100;

    localparam int VDAC_MULT_W = 20;
    localparam int VDAC_PROD_W = 33;
    localparam int VDAC_SHIFT  = 16;
    localparam int VDAC_OFFSET = 64452;
    localparam int IDAC_MULT   = 50;
    localparam int ICODE_W     = CURR_W + 6;

    localparam logic [VDAC_MULT_W-1:0] VDAC_MULT_Q16 = 20'd885015;
    localparam logic [VDAC_PROD_W-1:0] VDAC_FULL =
        VDAC_PROD_W'(VDAC_OFFSET) << VDAC_SHIFT;

    typedef struct packed {
        logic              enable;
        logic [VOLT_W-1:0] volt_setpoint;
        logic [CURR_W-1:0] curr_setpoint;
    } in_word_t;

    typedef struct packed {
        logic [VOLT_W-1:0] volt_now;
        logic [CURR_W-1:0] curr_now;
        logic [CODE_W-1:0] volt_dac_code;
        logic [CODE_W-1:0] curr_dac_code;
    } out_word_t;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_VGAP,
        MUL_VRECIP,
        MUL_CGAP,
        MUL_CRECIP,
        MUL_VDAC
    } mul_op_t;

    typedef struct packed {
        logic    take_upd;
        logic    take_clear;
        mul_op_t mul_op;
        logic    set_volt;
        logic    set_curr;
        logic    load_out;
    } cmd_t;

endpackage

>>> src/dual_setpoint_ramp_to_dac_unit.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake           Payload
// s_        input      s_valid / s_ready   drp_pkg::in_word_t
// m_        output     m_valid / m_ready   drp_pkg::out_word_t
//
// An enabled word passes five times through the shared multiplier and is then loaded into the
// result register; s_ready returns in the cycle after the load, and no new word is accepted until then.
// A disabled word clears the ramp state and gives no result.
// Reset is synchronous, active low, and clears the ramp state.
// A waiting result is held in the output register; the next word is accepted meanwhile
// and holds in its last step until the output register is free.

module dual_setpoint_ramp_to_dac_unit #(
    parameter int RAMP_STEPS = drp_pkg::RAMP_STEPS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  drp_pkg::in_word_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output drp_pkg::out_word_t m_data
);
    import drp_pkg::*;

    cmd_t cmd;
    logic out_busy;

    drp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_enable (s_data.enable),
        .s_ready  (s_ready),
        .out_busy (out_busy),
        .cmd      (cmd)
    );

    drp_datapath #(
        .RAMP_STEPS (RAMP_STEPS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .s_data   (s_data),
        .out_busy (out_busy),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

>>> src/drp_ctrl.sv
`timescale 1ns / 1ps

module drp_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    input  logic          s_enable,
    output logic          s_ready,
    input  logic          out_busy,
    output drp_pkg::cmd_t cmd
);
    import drp_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_VM1  = 7'b0000010,
        ST_VM2  = 7'b0000100,
        ST_CM1  = 7'b0001000,
        ST_CM2  = 7'b0010000,
        ST_VDAC = 7'b0100000,
        ST_OUT  = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    always_comb begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.mul_op     = MUL_NONE;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.take_upd   = accept && s_enable;
                cmd.take_clear = accept && !s_enable;
                if (accept && s_enable) begin
                    state_next = ST_VM1;
                end
            end
            ST_VM1: begin
                cmd.mul_op = MUL_VGAP;
                state_next = ST_VM2;
            end
            ST_VM2: begin
                cmd.mul_op = MUL_VRECIP;
                state_next = ST_CM1;
            end
            ST_CM1: begin
                cmd.set_volt = 1'b1;
                cmd.mul_op   = MUL_CGAP;
                state_next   = ST_CM2;
            end
            ST_CM2: begin
                cmd.mul_op = MUL_CRECIP;
                state_next = ST_VDAC;
            end
            ST_VDAC: begin
                cmd.set_curr = 1'b1;
                cmd.mul_op   = MUL_VDAC;
                state_next   = ST_OUT;
            end
            ST_OUT: begin
                if (!out_busy) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_busy_after_take: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_enable |=> !s_ready)
        else $error("input still ready after an enabled word was taken");

    a_volt_after_recip: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.set_volt |-> $past(cmd.mul_op == MUL_VRECIP))
        else $error("voltage value written without its quotient");

    a_curr_after_recip: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.set_curr |-> $past(cmd.mul_op == MUL_CRECIP))
        else $error("current value written without its quotient");

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> !out_busy && $past(cmd.mul_op == MUL_VDAC || state_reg == ST_OUT))
        else $error("result loaded out of sequence or over a waiting word");
`endif

endmodule

>>> src/drp_datapath.sv
`timescale 1ns / 1ps

module drp_datapath #(
    parameter int RAMP_STEPS = drp_pkg::RAMP_STEPS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  drp_pkg::cmd_t      cmd,
    input  drp_pkg::in_word_t  s_data,
    output logic               out_busy,
    output logic               m_valid,
    input  logic               m_ready,
    output drp_pkg::out_word_t m_data
);
    import drp_pkg::*;

    localparam int SW     = $clog2(RAMP_STEPS + 1);
    localparam int VGAP_W = VOLT_W + 1;
    localparam int CGAP_W = CURR_W + 1;
    localparam int MA     = VOLT_W + SW;
    localparam int SHIFT  = MA + SW;
    localparam int RB     = SHIFT + 1;
    localparam int MB     = (RB > VDAC_MULT_W) ? RB : VDAC_MULT_W;
    localparam int PW     = MA + MB;
    localparam logic [63:0] RECIP =
        ((64'd1 << SHIFT) + 64'(RAMP_STEPS) - 64'd1) / 64'(RAMP_STEPS);
    localparam logic [SW-1:0] STEPS_INIT = SW'(RAMP_STEPS);

    logic        [VOLT_W-1:0] volt_target_reg;
    logic        [VOLT_W-1:0] volt_present_reg;
    logic signed [VGAP_W-1:0] volt_gap_reg;
    logic        [SW-1:0]     volt_steps_reg;
    logic        [CURR_W-1:0] curr_target_reg;
    logic        [CURR_W-1:0] curr_present_reg;
    logic signed [CGAP_W-1:0] curr_gap_reg;
    logic        [SW-1:0]     curr_steps_reg;

    logic [PW-1:0] prod_reg;
    logic [PW-1:0] prod_next;
    logic [MA-1:0] mul_a;
    logic [MB-1:0] mul_b;

    logic        m_valid_reg;
    out_word_t   m_data_reg;
    out_word_t   out_next;

    logic                     volt_changed;
    logic signed [VGAP_W-1:0] volt_gap_next;
    logic        [SW-1:0]     volt_steps_sel;
    logic        [SW-1:0]     volt_steps_next;
    logic signed [VGAP_W-1:0] volt_abs;
    logic        [VOLT_W-1:0] volt_q;
    logic        [VOLT_W-1:0] volt_present_next;

    logic                     curr_changed;
    logic signed [CGAP_W-1:0] curr_gap_next;
    logic        [SW-1:0]     curr_steps_sel;
    logic        [SW-1:0]     curr_steps_next;
    logic signed [CGAP_W-1:0] curr_abs;
    logic        [CURR_W-1:0] curr_q;
    logic        [CURR_W-1:0] curr_present_next;

    logic [VDAC_PROD_W-1:0] vdac_prod;
    logic [VDAC_PROD_W-1:0] vdac_diff;
    logic [ICODE_W-1:0]     idac_prod;

    always_comb begin
        volt_changed    = (s_data.volt_setpoint != volt_target_reg);
        volt_gap_next   = $signed({1'b0, s_data.volt_setpoint})
                        - $signed({1'b0, volt_present_reg});
        volt_steps_sel  = volt_changed ? STEPS_INIT : volt_steps_reg;
        volt_steps_next = (volt_steps_sel == '0) ? '0 : volt_steps_sel - SW'(1);

        curr_changed    = (s_data.curr_setpoint != curr_target_reg);
        curr_gap_next   = $signed({1'b0, s_data.curr_setpoint})
                        - $signed({1'b0, curr_present_reg});
        curr_steps_sel  = curr_changed ? STEPS_INIT : curr_steps_reg;
        curr_steps_next = (curr_steps_sel == '0) ? '0 : curr_steps_sel - SW'(1);

        volt_abs = volt_gap_reg[VGAP_W-1] ? -volt_gap_reg : volt_gap_reg;
        curr_abs = curr_gap_reg[CGAP_W-1] ? -curr_gap_reg : curr_gap_reg;

        volt_q = prod_reg[SHIFT +: VOLT_W];
        curr_q = prod_reg[SHIFT +: CURR_W];
        volt_present_next = volt_gap_reg[VGAP_W-1] ? volt_target_reg + volt_q
                                                   : volt_target_reg - volt_q;
        curr_present_next = curr_gap_reg[CGAP_W-1] ? curr_target_reg + curr_q
                                                   : curr_target_reg - curr_q;
    end

    always_comb begin
        unique case (cmd.mul_op)
            MUL_VGAP: begin
                mul_a = MA'(volt_abs[VOLT_W-1:0]);
                mul_b = MB'(volt_steps_reg);
            end
            MUL_VRECIP, MUL_CRECIP: begin
                mul_a = prod_reg[MA-1:0];
                mul_b = MB'(RECIP);
            end
            MUL_CGAP: begin
                mul_a = MA'(curr_abs[CURR_W-1:0]);
                mul_b = MB'(curr_steps_reg);
            end
            MUL_VDAC: begin
                mul_a = MA'(volt_present_reg);
                mul_b = MB'(VDAC_MULT_Q16);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod_next = PW'(mul_a) * PW'(mul_b);
    end

    always_comb begin
        vdac_prod = prod_reg[VDAC_PROD_W-1:0];
        vdac_diff = VDAC_FULL - vdac_prod;
        idac_prod = ICODE_W'(curr_present_reg) * ICODE_W'(IDAC_MULT);

        out_next.volt_now      = volt_present_reg;
        out_next.curr_now      = curr_present_reg;
        out_next.volt_dac_code = (vdac_prod >= VDAC_FULL) ? '0
                               : vdac_diff[VDAC_SHIFT +: CODE_W];
        out_next.curr_dac_code = (idac_prod[ICODE_W-1:CODE_W] != '0) ? '1
                               : idac_prod[CODE_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            volt_target_reg  <= '0;
            volt_present_reg <= '0;
            volt_gap_reg     <= '0;
            volt_steps_reg   <= STEPS_INIT;
            curr_target_reg  <= '0;
            curr_present_reg <= '0;
            curr_gap_reg     <= '0;
            curr_steps_reg   <= STEPS_INIT;
            m_valid_reg      <= 1'b0;
        end else begin
            if (cmd.take_clear) begin
                volt_target_reg  <= '0;
                volt_present_reg <= '0;
                volt_gap_reg     <= '0;
                volt_steps_reg   <= STEPS_INIT;
                curr_target_reg  <= '0;
                curr_present_reg <= '0;
                curr_gap_reg     <= '0;
                curr_steps_reg   <= STEPS_INIT;
            end else if (cmd.take_upd) begin
                volt_target_reg <= s_data.volt_setpoint;
                volt_steps_reg  <= volt_steps_next;
                curr_target_reg <= s_data.curr_setpoint;
                curr_steps_reg  <= curr_steps_next;
                if (volt_changed) begin
                    volt_gap_reg <= volt_gap_next;
                end
                if (curr_changed) begin
                    curr_gap_reg <= curr_gap_next;
                end
            end
            if (cmd.set_volt) begin
                volt_present_reg <= volt_present_next;
            end
            if (cmd.set_curr) begin
                curr_present_reg <= curr_present_next;
            end
            if (cmd.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mul_op != MUL_NONE) begin
            prod_reg <= prod_next;
        end
        if (cmd.load_out) begin
            m_data_reg <= out_next;
        end
    end

    assign out_busy = m_valid_reg && !m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

endmodule
